// ===== rtl/bayer_bilinear_demosaic_macros.svh =====
// Assertion macros shared by the demosaic RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef BAYER_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_MACROS_SVH

`ifndef ASSERT_OFF

`define BBD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define BBD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bbd_pkg.sv =====
// Shared constants, types and the CFA lookup for the Bayer demosaic.
// No dependencies; used by every other file except the line buffer and the macros.
`timescale 1ns / 1ps

package bbd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COL_W         = 12;
    localparam int ROW_W         = 16;
    localparam int RGB_W         = 18;
    localparam int FRAME_W_BITS  = 13;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int LANES         = 4;
    localparam int QUEUE_DEPTH   = 8;
    localparam int QUEUE_PTR_W   = 3;
    localparam int QCNT_W        = QUEUE_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CFA_PATTERN  = 2'd2;

    localparam logic [1:0] CLR_RED   = 2'd0;
    localparam logic [1:0] CLR_GREEN = 2'd1;
    localparam logic [1:0] CLR_BLUE  = 2'd2;

    // window row/column taps: oldest, middle, newest
    localparam logic [1:0] SEL_OLD = 2'd0;
    localparam logic [1:0] SEL_MID = 2'd1;
    localparam logic [1:0] SEL_NEW = 2'd2;

    // [pattern][{y odd, x odd}]: RGGB, GRBG, GBRG, BGGR
    localparam logic [0:3][0:3][1:0] CFA_MAP = '{
        '{CLR_RED,   CLR_GREEN, CLR_GREEN, CLR_BLUE },
        '{CLR_GREEN, CLR_RED,   CLR_BLUE,  CLR_GREEN},
        '{CLR_GREEN, CLR_BLUE,  CLR_RED,   CLR_GREEN},
        '{CLR_BLUE,  CLR_GREEN, CLR_GREEN, CLR_RED  }
    };

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
        logic             frame_end;
    } t_result;

    typedef struct packed {
        logic [1:0] row_up;
        logic [1:0] row_ctr;
        logic [1:0] row_dn;
        logic [1:0] col_lf;
        logic [1:0] col_ctr;
        logic [1:0] col_rt;
        logic       x_odd;
        logic       y_odd;
    } t_lane_ctl;

    function automatic logic [1:0] cfa_colour(logic [1:0] pattern, logic y_odd, logic x_odd);
        return CFA_MAP[pattern][{y_odd, x_odd}];
    endfunction

endpackage

// ===== rtl/bbd_if.sv =====
// Valid/ready stream interfaces for raw samples in and RGB words out.
// Depends on bbd_pkg for field widths.
`timescale 1ns / 1ps

interface bbd_in_if;
    import bbd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bbd_out_if;
    import bbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
    logic             frame_end;

    modport source (output valid, output out_col, output out_row, output red,
                    output green, output blue, output frame_end, input ready);
    modport sink   (input valid, input out_col, input out_row, input red,
                    input green, input blue, input frame_end, output ready);
endinterface

// ===== rtl/bbd_line_buf.sv =====
// Line memory holding the two previous rows, one {older, prior} pair per column.
// Registered read; no reset on contents. Depends on nothing else.
`timescale 1ns / 1ps

module bbd_line_buf #(
    parameter int DEPTH = 4096,
    parameter int DW    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bbd_interp.sv =====
// One interpolation lane: picks taps from the 3x3 window and forms RGB times four.
// Depends on bbd_pkg.
`timescale 1ns / 1ps

module bbd_interp #(
    parameter int SB = 16
) (
    input  logic [1:0]                 i_cfa,
    input  logic [2:0][2:0][SB-1:0]    i_win,
    input  bbd_pkg::t_lane_ctl         i_ctl,
    output logic [bbd_pkg::RGB_W-1:0]  o_red,
    output logic [bbd_pkg::RGB_W-1:0]  o_green,
    output logic [bbd_pkg::RGB_W-1:0]  o_blue
);
    import bbd_pkg::*;

    logic [SB-1:0] pix, up, dn, lf, rt, ul, ur, dl, dr;
    logic [SB:0]   sum_h, sum_v;
    logic [SB+1:0] orth, diag, pix4, hv, vv;
    logic [1:0]    colour, colour_rt;

    assign pix = i_win[i_ctl.row_ctr][i_ctl.col_ctr];
    assign up  = i_win[i_ctl.row_up][i_ctl.col_ctr];
    assign dn  = i_win[i_ctl.row_dn][i_ctl.col_ctr];
    assign lf  = i_win[i_ctl.row_ctr][i_ctl.col_lf];
    assign rt  = i_win[i_ctl.row_ctr][i_ctl.col_rt];
    assign ul  = i_win[i_ctl.row_up][i_ctl.col_lf];
    assign ur  = i_win[i_ctl.row_up][i_ctl.col_rt];
    assign dl  = i_win[i_ctl.row_dn][i_ctl.col_lf];
    assign dr  = i_win[i_ctl.row_dn][i_ctl.col_rt];

    assign sum_h = {1'b0, lf} + {1'b0, rt};
    assign sum_v = {1'b0, up} + {1'b0, dn};
    assign orth  = {1'b0, sum_h} + {1'b0, sum_v};
    assign diag  = ({2'b0, ul} + {2'b0, ur}) + ({2'b0, dl} + {2'b0, dr});
    assign pix4  = {pix, 2'b00};
    assign hv    = {sum_h, 1'b0};
    assign vv    = {sum_v, 1'b0};

    assign colour    = cfa_colour(i_cfa, i_ctl.y_odd, i_ctl.x_odd);
    assign colour_rt = cfa_colour(i_cfa, i_ctl.y_odd, ~i_ctl.x_odd);

    always_comb begin
        case (colour)
            CLR_RED: begin
                o_red   = RGB_W'(pix4);
                o_green = RGB_W'(orth);
                o_blue  = RGB_W'(diag);
            end
            CLR_BLUE: begin
                o_red   = RGB_W'(diag);
                o_green = RGB_W'(orth);
                o_blue  = RGB_W'(pix4);
            end
            default: begin
                o_green = RGB_W'(pix4);
                if (colour_rt == CLR_RED) begin
                    o_red  = RGB_W'(hv);
                    o_blue = RGB_W'(vv);
                end else begin
                    o_red  = RGB_W'(vv);
                    o_blue = RGB_W'(hv);
                end
            end
        endcase
    end

endmodule

// ===== rtl/bbd_out_queue.sv =====
// Eight-word result queue: takes up to four words a cycle, drives one word out.
// Depends on bbd_pkg, bbd_if and the assertion macros.
`timescale 1ns / 1ps
`include "bayer_bilinear_demosaic_macros.svh"

module bbd_out_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bbd_pkg::LANES-1:0]   i_push_en,
    input  bbd_pkg::t_result            i_push_data [bbd_pkg::LANES],
    output logic [bbd_pkg::QCNT_W-1:0]  o_count,
    bbd_out_if.source                   o_rgb
);
    import bbd_pkg::*;

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [QCNT_W-1:0]      r_cnt, n_cnt;
    logic [QUEUE_PTR_W-1:0] off [LANES];
    logic [QUEUE_PTR_W-1:0] push_n;
    logic                   pop;
    t_result                head;

    // slot offset of each lane among the enabled ones
    always_comb begin
        logic [QUEUE_PTR_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < LANES; k++) begin
            off[k] = acc;
            acc    = acc + QUEUE_PTR_W'(i_push_en[k]);
        end
        push_n = acc;
    end

    assign pop    = o_rgb.valid && o_rgb.ready;
    assign n_wptr = r_wptr + push_n;
    assign n_rptr = r_rptr + QUEUE_PTR_W'(pop);
    assign n_cnt  = r_cnt + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            if (i_push_en[k]) begin
                r_mem[r_wptr + off[k]] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    assign head            = r_mem[r_rptr];
    assign o_count         = r_cnt;
    assign o_rgb.valid     = (r_cnt != '0);
    assign o_rgb.out_col   = head.out_col;
    assign o_rgb.out_row   = head.out_row;
    assign o_rgb.red       = head.red;
    assign o_rgb.green     = head.green;
    assign o_rgb.blue      = head.blue;
    assign o_rgb.frame_end = head.frame_end;

    `BBD_ASSERT_IMPLY(a_q_no_overflow, i_clk, i_rst_n, push_n != '0, (r_cnt + QCNT_W'(push_n) - QCNT_W'(pop)) <= QCNT_W'(QUEUE_DEPTH))
    `BBD_ASSERT_IMPLY(a_q_count_tracks, i_clk, i_rst_n, $past(i_rst_n), r_cnt == ($past(r_cnt) + QCNT_W'($past(push_n)) - QCNT_W'($past(pop))))
    `BBD_ASSERT_IMPLY(a_q_ptr_match, i_clk, i_rst_n, r_cnt != QCNT_W'(QUEUE_DEPTH), (r_wptr - r_rptr) == QUEUE_PTR_W'(r_cnt))

endmodule

// ===== rtl/bayer_bilinear_demosaic.sv =====
// Top level of the streaming 3x3 bilinear Bayer demosaic.
// Depends on bbd_pkg, bbd_if, bbd_line_buf, bbd_interp, bbd_out_queue and the macros.
// In raster order, one raw sample in and one RGB word out per clock when not stalled.
// A sample is registered with its two line-memory taps, and in the next clock it
// shifts the 3x3 window and four interpolation lanes fill the output queue, from
// whose registered words the output is driven. Output runs one row behind the input:
// samples of row 0 and of column 0 yield no word, other mid-row samples one, the last
// sample of a row two, and samples of the last row two or four (that row is finished
// in the same pass). The output port sets the sustained rate: the input is held off
// whenever the queued words and those pending in the sample stage exceed four, as at
// row ends and along the last row.
// Words carry their column and row; frame_end marks the bottom-right pixel.
// Frame edges mirror without repeating the edge pixel. Colors are times four.
// Line memories need no clearing; configure only while the block is idle.
`timescale 1ns / 1ps
`include "bayer_bilinear_demosaic_macros.svh"

module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bbd_in_if.sink                           i_pix,
    bbd_out_if.source                        o_rgb
);
    import bbd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (CNT_W + 1 > FRAME_W_BITS) ? CNT_W + 1 : FRAME_W_BITS;
    localparam int SB     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int RST_W  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam logic [CNT_W-1:0] WLAST_RST = CNT_W'(RST_W - 1);

    // configuration
    logic [CNT_W-1:0] r_wlast, n_wlast;
    logic [ROW_W-1:0] r_hlast, n_hlast;
    logic [1:0]       r_cfa;
    logic [CMP_W-1:0] cfg_w;

    assign cfg_w = CMP_W'(i_cfg_data[FRAME_W_BITS-1:0]);

    always_comb begin
        if (cfg_w < CMP_W'(2)) begin
            n_wlast = CNT_W'(1);
        end else if (cfg_w > CMP_W'(MAX_WIDTH)) begin
            n_wlast = CNT_W'(MAX_WIDTH - 1);
        end else begin
            n_wlast = CNT_W'(cfg_w - CMP_W'(1));
        end
        if (i_cfg_data < CFG_DATA_W'(2)) begin
            n_hlast = ROW_W'(1);
        end else begin
            n_hlast = ROW_W'(i_cfg_data - CFG_DATA_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= WLAST_RST;
            r_hlast <= ROW_W'(1);
            r_cfa   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_wlast <= n_wlast;
                CFG_FRAME_HEIGHT: r_hlast <= n_hlast;
                CFG_CFA_PATTERN:  r_cfa   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // position of the incoming sample
    logic [CNT_W-1:0] r_col, n_col, cur_c;
    logic [ROW_W-1:0] r_row, n_row, cur_r;
    logic [ROW_W:0]   row_inc;
    logic             wrap_col, at_end, at_last, has_col, has_row, accept;
    logic [LANES-1:0] cur_en;
    logic [2:0]       cur_n;

    assign accept   = i_pix.valid && i_pix.ready;
    assign wrap_col = (r_col > r_wlast);
    assign cur_c    = wrap_col ? '0 : r_col;
    assign row_inc  = {1'b0, r_row} + (ROW_W + 1)'(wrap_col);
    assign cur_r    = (row_inc > {1'b0, r_hlast}) ? '0 : row_inc[ROW_W-1:0];
    assign at_end   = (cur_c == r_wlast);
    assign at_last  = (cur_r == r_hlast);
    assign has_col  = (cur_c != '0);
    assign has_row  = (cur_r != '0);

    assign cur_en[0] = has_col && has_row;
    assign cur_en[1] = has_col && has_row && at_end;
    assign cur_en[2] = has_col && at_last;
    assign cur_en[3] = has_col && at_last && at_end;
    assign cur_n = 3'(cur_en[0]) + 3'(cur_en[1]) + 3'(cur_en[2]) + 3'(cur_en[3]);

    always_comb begin
        if (at_end) begin
            n_col = '0;
            n_row = at_last ? '0 : cur_r + ROW_W'(1);
        end else begin
            n_col = cur_c + CNT_W'(1);
            n_row = cur_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // sample stage
    logic             r_s1_valid;
    logic [SB-1:0]    r_s1_sample;
    logic [CNT_W-1:0] r_s1_c;
    logic [ROW_W-1:0] r_s1_r;
    logic             r_s1_first, r_s1_row1, r_s1_end, r_s1_lastrow;
    logic [LANES-1:0] r_s1_en;
    logic [2:0]       r_s1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample  <= i_pix.sample[SB-1:0];
            r_s1_c       <= cur_c;
            r_s1_r       <= cur_r;
            r_s1_first   <= (cur_c == CNT_W'(1));
            r_s1_row1    <= (cur_r == ROW_W'(1));
            r_s1_end     <= at_end;
            r_s1_lastrow <= at_last;
            r_s1_en      <= cur_en;
            r_s1_n       <= cur_n;
        end
    end

    // line memory: {row r-2, row r-1} per column
    logic [2*SB-1:0] lb_rd;
    logic [SB-1:0]   tap_top, tap_mid;

    bbd_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * SB)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_c),
        .o_rd_data (lb_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_c),
        .i_wr_data ({tap_mid, r_s1_sample})
    );

    assign tap_top = lb_rd[2*SB-1:SB];
    assign tap_mid = lb_rd[SB-1:0];

    // 3x3 window, [row][col], newest column at index 2
    logic [2:0][2:0][SB-1:0] r_win, n_win;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = tap_top;
        n_win[1][2] = tap_mid;
        n_win[2][2] = r_s1_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // lanes: 0 (c-1, r-1), 1 (w-1, r-1), 2 (c-1, r), 3 (w-1, r)
    t_lane_ctl        lane_ctl [LANES];
    t_result          lane_res [LANES];
    logic [RGB_W-1:0] lane_r [LANES];
    logic [RGB_W-1:0] lane_g [LANES];
    logic [RGB_W-1:0] lane_b [LANES];
    logic [CNT_W-1:0] c_m1;
    logic [ROW_W-1:0] r_m1;

    assign c_m1 = r_s1_c - CNT_W'(1);
    assign r_m1 = r_s1_r - ROW_W'(1);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (k < 2) begin
                lane_ctl[k].row_up  = r_s1_row1 ? SEL_NEW : SEL_OLD;
                lane_ctl[k].row_ctr = SEL_MID;
                lane_ctl[k].row_dn  = SEL_NEW;
                lane_ctl[k].y_odd   = ~r_s1_r[0];
                lane_res[k].out_row = r_m1;
            end else begin
                lane_ctl[k].row_up  = SEL_MID;
                lane_ctl[k].row_ctr = SEL_NEW;
                lane_ctl[k].row_dn  = SEL_MID;
                lane_ctl[k].y_odd   = r_s1_r[0];
                lane_res[k].out_row = r_s1_r;
            end
            if ((k % 2) == 0) begin
                lane_ctl[k].col_lf  = r_s1_first ? SEL_NEW : SEL_OLD;
                lane_ctl[k].col_ctr = SEL_MID;
                lane_ctl[k].col_rt  = SEL_NEW;
                lane_ctl[k].x_odd   = ~r_s1_c[0];
                lane_res[k].out_col = COL_W'(c_m1);
            end else begin
                lane_ctl[k].col_lf  = SEL_MID;
                lane_ctl[k].col_ctr = SEL_NEW;
                lane_ctl[k].col_rt  = SEL_MID;
                lane_ctl[k].x_odd   = r_s1_c[0];
                lane_res[k].out_col = COL_W'(r_s1_c);
            end
            lane_res[k].red       = lane_r[k];
            lane_res[k].green     = lane_g[k];
            lane_res[k].blue      = lane_b[k];
            lane_res[k].frame_end = (k == LANES - 1);
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bbd_interp #(
            .SB (SB)
        ) u_interp (
            .i_cfa   (r_cfa),
            .i_win   (n_win),
            .i_ctl   (lane_ctl[g]),
            .o_red   (lane_r[g]),
            .o_green (lane_g[g]),
            .o_blue  (lane_b[g])
        );
    end

    // output queue and input flow control
    logic [LANES-1:0]  push_en;
    logic [QCNT_W-1:0] q_count;
    logic [2:0]        s1_pend;

    assign push_en = r_s1_valid ? r_s1_en : '0;
    assign s1_pend = r_s1_valid ? r_s1_n : '0;
    assign i_pix.ready = ((q_count + QCNT_W'(s1_pend)) <= QCNT_W'(LANES));

    bbd_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_en   (push_en),
        .i_push_data (lane_res),
        .o_count     (q_count),
        .o_rgb       (o_rgb)
    );

    `BBD_ASSERT_NEXT(a_accept_loads_stage, i_clk, i_rst_n,
                     i_pix.valid && i_pix.ready, r_s1_valid)
    `BBD_ASSERT_IMPLY(a_first_col_silent, i_clk, i_rst_n,
                      r_s1_valid && (r_s1_c == '0), r_s1_n == 3'd0)
    `BBD_ASSERT_IMPLY(a_full_burst_row_end, i_clk, i_rst_n,
                      r_s1_valid && (r_s1_n == 3'(LANES)), r_s1_end && r_s1_lastrow)

endmodule

// ===== sim/bayer_bilinear_demosaic_test.sv =====
// Self-checking testbench for bayer_bilinear_demosaic: directed frames, flat and mixed,
// then random frames, against an internal bilinear demosaic predictor with random stalls.
// Depends on bbd_pkg, bbd_if and the demosaic RTL.
`timescale 1ns / 1ps

module bayer_bilinear_demosaic_test;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int WIDE_ITEMS   = 24;
    localparam int FRAME_MAX    = 4096;
    localparam int TIMEOUT_NS   = 30_000_000;
    localparam logic [17:0] FULL_LEVEL = 18'd262140;
    localparam logic [bbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {CFA_RGGB, CFA_GRBG, CFA_GBRG, CFA_BGGR} t_cfa;
    typedef enum logic [1:0] {SITE_RED, SITE_GREEN, SITE_BLUE} t_site;

    typedef struct packed {
        logic        set_cfg;
        logic [15:0] width_val;
        logic [15:0] height_val;
        t_cfa        pattern;
        logic [15:0] sample;
        logic        typed;
        logic [17:0] level;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIRECTED [0:DIR_ROWS-1] = '{
        // reset setup (4096 x 2), part of row 0, then shrink to 4 wide: row 1 is last
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b1, 16'd4, 16'd2, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        '{1'b0, 16'd0, 16'd0, CFA_RGGB, 16'hFFFF, 1'b1, FULL_LEVEL},
        // width 0 and height 1 both clamp to 2
        '{1'b1, 16'd0, 16'd1, CFA_GBRG, 16'h0000, 1'b1, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GBRG, 16'h0000, 1'b1, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GBRG, 16'h0000, 1'b1, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GBRG, 16'h0000, 1'b1, 18'd0},
        // 3 x 3 GRBG, mixed extremes
        '{1'b1, 16'd3, 16'd3, CFA_GRBG, 16'h0000, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'hFFFF, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'hAAAA, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'h5555, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'h0001, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'h8000, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'hFFFF, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'h0000, 1'b0, 18'd0},
        '{1'b0, 16'd0, 16'd0, CFA_GRBG, 16'h7FFF, 1'b0, 18'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data;

    bbd_in_if  pix_if ();
    bbd_out_if rgb_if ();

    bayer_bilinear_demosaic uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_rgb      (rgb_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state
    logic [15:0] older_row [0:FRAME_MAX-1];
    logic [15:0] prior_row [0:FRAME_MAX-1];
    logic [15:0] win [0:2][0:2];
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  cfa_reg;

    bbd_pkg::t_result pixel_q[$];
    int unsigned fault_count;
    int unsigned random_sent;
    bit          idle_mode;
    bit          fixed_on;
    logic [17:0] fixed_level;

    function automatic int unsigned clamp_width(logic [12:0] v);
        if (v < 2) return 2;
        if (v > FRAME_MAX) return FRAME_MAX;
        return v;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg < 2) ? 2 : height_reg;
    endfunction

    // red sits at cell position == pattern, blue at the opposite corner
    function automatic t_site site_of(int unsigned x, int unsigned y);
        logic [1:0] pos;
        pos = {y[0], x[0]};
        if (pos == cfa_reg) return SITE_RED;
        if (pos == (cfa_reg ^ 2'b11)) return SITE_BLUE;
        return SITE_GREEN;
    endfunction

    task automatic predict_pixel(input int unsigned x, input int unsigned y,
                                 input int ru, input int rc, input int rd,
                                 input int cl, input int cc, input int cr,
                                 input bit frame_last);
        logic [17:0] ctr, up, dn, lf, rt, orth, diag, hv, vv;
        bbd_pkg::t_result px;
        ctr  = 18'(win[rc][cc]);
        up   = 18'(win[ru][cc]);
        dn   = 18'(win[rd][cc]);
        lf   = 18'(win[rc][cl]);
        rt   = 18'(win[rc][cr]);
        orth = up + dn + lf + rt;
        diag = 18'(win[ru][cl]) + win[ru][cr] + win[rd][cl] + win[rd][cr];
        hv   = (lf + rt) << 1;
        vv   = (up + dn) << 1;
        px.out_col   = x[11:0];
        px.out_row   = y[15:0];
        px.frame_end = frame_last;
        case (site_of(x, y))
            SITE_RED: begin
                px.red = ctr << 2; px.green = orth; px.blue = diag;
            end
            SITE_BLUE: begin
                px.blue = ctr << 2; px.green = orth; px.red = diag;
            end
            default: begin
                px.green = ctr << 2;
                if (site_of(x + 1, y) == SITE_RED) begin
                    px.red = hv; px.blue = vv;
                end else begin
                    px.blue = hv; px.red = vv;
                end
            end
        endcase
        if (fixed_on) begin
            px.red = fixed_level; px.green = fixed_level; px.blue = fixed_level;
        end
        pixel_q = {pixel_q, px};
    endtask

    task automatic demosaic_step(input logic [15:0] s);
        int unsigned w, h, c, r;
        int cl, ru;
        bit end_col, last_row;
        w = clamp_width(width_reg);
        h = active_height();
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        c = col_cnt;
        r = row_cnt;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = older_row[c];
        win[1][2] = prior_row[c];
        win[2][2] = s;
        older_row[c] = prior_row[c];
        prior_row[c] = s;
        if (c >= 1) begin
            cl = (c == 1) ? 2 : 0;
            end_col = (c == w - 1);
            last_row = (r == h - 1);
            if (r >= 1) begin
                ru = (r == 1) ? 2 : 0;
                predict_pixel(c - 1, r - 1, ru, 1, 2, cl, 1, 2, 1'b0);
                if (end_col) predict_pixel(w - 1, r - 1, ru, 1, 2, 1, 2, 1, 1'b0);
            end
            if (last_row) begin
                predict_pixel(c - 1, r, 1, 2, 1, cl, 1, 2, 1'b0);
                if (end_col) predict_pixel(w - 1, r, 1, 2, 1, 1, 2, 1, 1'b1);
            end
        end
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
    endtask

    function automatic int unsigned pick_pause();
        return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic int unsigned sender_gap();
        if (!idle_mode || $urandom_range(0, 3) != 0) return 0;
        return pick_pause();
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_sample(input logic [15:0] s, input int unsigned gap);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid  <= 1'b1;
        pix_if.sample <= s;
        do @(posedge clk); while (!pix_if.ready);
        demosaic_step(s);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbd_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            bbd_pkg::CFG_FRAME_WIDTH:  width_reg  = data[12:0];
            bbd_pkg::CFG_FRAME_HEIGHT: height_reg = data;
            bbd_pkg::CFG_CFA_PATTERN:  cfa_reg    = data[1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setup(input logic [15:0] w, input logic [15:0] h,
                               input logic [1:0] pat);
        wait_idle();
        write_reg(bbd_pkg::CFG_FRAME_WIDTH, w);
        write_reg(bbd_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(bbd_pkg::CFG_CFA_PATTERN, {14'd0, pat});
        write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    // either a fixed count of samples or up to the end of the current frame
    task automatic feed_random(input int unsigned count, input bit to_frame_end);
        int unsigned k;
        k = 0;
        do begin
            if ($urandom_range(0, 59) == 0) wait_idle();
            push_sample(rand_sample(), sender_gap());
            k++;
        end while (to_frame_end ? (col_cnt != 0 || row_cnt != 0) : (k < count));
        random_sent += k;
    endtask

    task automatic compare_field(input string name, input logic [17:0] want,
                                 input logic [17:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk) begin : rgb_monitor
        bbd_pkg::t_result want;
        if (rst_n && rgb_if.valid && rgb_if.ready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected word at col %0d row %0d", rgb_if.out_col, rgb_if.out_row);
                fault_count++;
            end else begin
                want = pixel_q.pop_front();
                compare_field("out_col", want.out_col, rgb_if.out_col);
                compare_field("out_row", want.out_row, rgb_if.out_row);
                compare_field("red", want.red, rgb_if.red);
                compare_field("green", want.green, rgb_if.green);
                compare_field("blue", want.blue, rgb_if.blue);
                compare_field("frame_end", want.frame_end, rgb_if.frame_end);
            end
        end
    end

    initial begin : rgb_stall
        int unsigned run;
        rgb_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            rgb_if.ready <= 1'b1;
            if (!idle_mode) begin
                @(posedge clk);
            end else begin
                run = $urandom_range(1, 8);
                repeat (run) @(posedge clk);
                rgb_if.ready <= 1'b0;
                repeat (pick_pause()) @(posedge clk);
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("** bayer_bilinear_demosaic: FAILED **");
        $finish;
    end

    initial begin
        int unsigned iter, cur_w;
        bit mid_frame, wide_done, tall_done;
        logic [15:0] w_val, h_val;
        logic [1:0] pat;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        pix_if.valid  <= 1'b0;
        pix_if.sample <= '0;
        for (int i = 0; i < FRAME_MAX; i++) begin
            older_row[i] = '0;
            prior_row[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        col_cnt     = 0;
        row_cnt     = 0;
        width_reg   = 13'd4096;
        height_reg  = 16'd2;
        cfa_reg     = CFA_RGGB;
        fault_count = 0;
        random_sent = 0;
        idle_mode   = 1'b1;
        fixed_on    = 1'b0;
        fixed_level = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIRECTED[i].set_cfg)
                apply_setup(DIRECTED[i].width_val, DIRECTED[i].height_val,
                            DIRECTED[i].pattern);
            fixed_on    = DIRECTED[i].typed;
            fixed_level = DIRECTED[i].level;
            push_sample(DIRECTED[i].sample, sender_gap());
        end
        fixed_on = 1'b0;

        iter      = 0;
        wide_done = 1'b0;
        tall_done = 1'b0;
        while (random_sent < RANDOM_ITEMS) begin
            mid_frame = (col_cnt != 0) || (row_cnt != 0);
            idle_mode = ($urandom_range(0, 3) != 0);
            pat       = 2'($urandom_range(0, 3));
            if (!wide_done && iter >= 4 && !mid_frame) begin
                // oversize width clamps to the full line length; short first row,
                // left open so that the next setup narrows it
                wide_done = 1'b1;
                apply_setup(16'hFFFF, 16'd2, pat);
                feed_random(WIDE_ITEMS, 1'b0);
            end else if (!tall_done && iter >= 2 && !mid_frame) begin
                // tallest frame, left open; the next setup wraps it
                tall_done = 1'b1;
                apply_setup(16'd3, 16'hFFFF, pat);
                feed_random(4 * 3, 1'b0);
            end else begin
                cur_w = clamp_width(width_reg);
                w_val = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                     : 16'($urandom_range(2, 9));
                // lines never widen inside a frame: wider columns were never stored
                if (mid_frame && clamp_width(w_val[12:0]) > cur_w) w_val = 16'(cur_w);
                h_val = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                     : 16'($urandom_range(2, 6));
                apply_setup(w_val, h_val, pat);
                if ($urandom_range(0, 4) == 0)
                    feed_random($urandom_range(1, clamp_width(width_reg) * active_height() - 1),
                                1'b0);
                else
                    feed_random(0, 1'b1);
            end
            iter++;
        end

        wait_idle();
        if (fault_count == 0)
            $display("** bayer_bilinear_demosaic: PASSED **");
        else
            $display("** bayer_bilinear_demosaic: FAILED **");
        $finish;
    end

endmodule
